// File: rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps
// types, constants and the command decode for the skid-steer command decoder
// no dependencies

package ssd_pkg;

  localparam int unsigned SPD_W      = 7;
  localparam int unsigned PWM_W      = 8;
  localparam int unsigned NUM_MOTOR  = 4;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned BYTE_W     = 8;

  // speed percent full scale, pwm = min(s,100) * 255 / 100 by reciprocal
  localparam logic [SPD_W-1:0] PCT_MAX   = 7'd100;
  localparam int unsigned      PWM_SHIFT = 19;
  // 255 * ceil(2^19 / 100)
  localparam logic [20:0]      PWM_RECIP = 21'd1336965;

  // power-up values of the configuration registers and state
  localparam logic [SPD_W-1:0]     DRIVE_CAP_RST   = 7'd25;
  localparam logic [SPD_W-1:0]     TURN_CAP_RST    = 7'd100;
  localparam logic [SPD_W-1:0]     STEP_RST        = 7'd5;
  localparam logic [SPD_W-1:0]     FLOOR_RST       = 7'd5;
  localparam logic [SPD_W-1:0]     DEFAULT_RST     = 7'd10;
  localparam logic [NUM_MOTOR-1:0] INVERT_RST      = 4'd10;
  localparam logic [SPD_W-1:0]     SPEED_RST       = 7'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_CAP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_CAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_DFLT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 3'd5;

  // reported command kinds
  localparam logic [KIND_W-1:0] KIND_FWD    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BACK   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LEFT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RIGHT  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_STOP   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_HOME   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_ADJUST = 3'd6;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_FWD,
    CMD_BACK,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_STOP,
    CMD_HOME,
    CMD_DRV_UP,
    CMD_DRV_DN,
    CMD_TRN_UP,
    CMD_TRN_DN
  } cmd_e;

  typedef struct packed {
    logic [SPD_W-1:0]     drive_cap;
    logic [SPD_W-1:0]     turn_cap;
    logic [SPD_W-1:0]     speed_step;
    logic [SPD_W-1:0]     speed_floor;
    logic [SPD_W-1:0]     speed_default;
    logic [NUM_MOTOR-1:0] invert_mask;
  } cfg_t;

  typedef struct packed {
    logic [PWM_W-1:0]     pwm;
    logic [NUM_MOTOR-1:0] dir;
    logic                 led;
    logic [SPD_W-1:0]     drive_speed;
    logic [SPD_W-1:0]     turn_speed;
    logic [KIND_W-1:0]    kind;
  } res_t;

  // command letter decode
  function automatic cmd_e decode_cmd(input logic [BYTE_W-1:0] b);
    cmd_e c;
    unique case (b) inside
      "w", "W", "f": c = CMD_FWD;
      "s", "S", "b": c = CMD_BACK;
      "a", "A", "l": c = CMD_LEFT;
      "d", "D", "r": c = CMD_RIGHT;
      "x", "X", " ": c = CMD_STOP;
      "h", "H":      c = CMD_HOME;
      "q", "Q":      c = CMD_DRV_UP;
      "z", "Z":      c = CMD_DRV_DN;
      "e", "E":      c = CMD_TRN_UP;
      "c", "C":      c = CMD_TRN_DN;
      default:       c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/ssd_intf.sv
`timescale 1ns / 1ps
// valid/ready channels of the skid-steer command decoder: command in,
// result out and configuration write; depends on ssd_pkg

interface ssd_cmd_if
  import ssd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ssd_res_if
  import ssd_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [PWM_W-1:0]     pwm_right_front;
  logic [PWM_W-1:0]     pwm_left_front;
  logic [PWM_W-1:0]     pwm_right_back;
  logic [PWM_W-1:0]     pwm_left_back;
  logic [NUM_MOTOR-1:0] dir_bits;
  logic                 led_on;
  logic [SPD_W-1:0]     drive_speed_now;
  logic [SPD_W-1:0]     turn_speed_now;
  logic [KIND_W-1:0]    command_kind;

  modport source (
    output valid, output pwm_right_front, output pwm_left_front,
    output pwm_right_back, output pwm_left_back, output dir_bits,
    output led_on, output drive_speed_now, output turn_speed_now,
    output command_kind, input ready
  );
  modport sink (
    input valid, input pwm_right_front, input pwm_left_front,
    input pwm_right_back, input pwm_left_back, input dir_bits,
    input led_on, input drive_speed_now, input turn_speed_now,
    input command_kind, output ready
  );
endinterface

interface ssd_cfg_if
  import ssd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

// File: rtl/core/ssd_cfg.sv
`timescale 1ns / 1ps
// configuration register file of the skid-steer command decoder
// depends on ssd_pkg

module ssd_cfg
  import ssd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_index_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  // register write decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        REG_DRIVE_CAP:   cfg_d.drive_cap     = wr_data_i[SPD_W-1:0];
        REG_TURN_CAP:    cfg_d.turn_cap      = wr_data_i[SPD_W-1:0];
        REG_SPEED_STEP:  cfg_d.speed_step    = wr_data_i[SPD_W-1:0];
        REG_SPEED_FLOOR: cfg_d.speed_floor   = wr_data_i[SPD_W-1:0];
        REG_SPEED_DFLT:  cfg_d.speed_default = wr_data_i[SPD_W-1:0];
        REG_INVERT_MASK: cfg_d.invert_mask   = wr_data_i[NUM_MOTOR-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.drive_cap     <= DRIVE_CAP_RST;
      cfg_q.turn_cap      <= TURN_CAP_RST;
      cfg_q.speed_step    <= STEP_RST;
      cfg_q.speed_floor   <= FLOOR_RST;
      cfg_q.speed_default <= DEFAULT_RST;
      cfg_q.invert_mask   <= INVERT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/ssd_exec.sv
`timescale 1ns / 1ps
// command execution: decode, speed adjust, skid-steer mix and pwm scaling,
// with the drive state registers; depends on ssd_pkg

module ssd_exec
  import ssd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  cfg_t              cfg_i,
  output logic              hit_o,
  output res_t              res_o
);

  logic [SPD_W-1:0]     drive_speed_q, drive_speed_d;
  logic [SPD_W-1:0]     turn_speed_q, turn_speed_d;
  logic [PWM_W-1:0]     pwm_q, pwm_d;
  logic [NUM_MOTOR-1:0] dir_q, dir_d;
  logic                 led_q, led_d;

  cmd_e                 cmd;
  logic [SPD_W-1:0]     sd, st, sel, mag;
  logic [27:0]          pwm_prod;
  logic [PWM_W-1:0]     pwm_new;
  logic                 left_neg, right_neg, motion;
  logic [NUM_MOTOR-1:0] neg_vec;
  logic [SPD_W:0]       raise_src, raise_sum, lower_diff;
  logic [SPD_W-1:0]     raise_cap, raise_val, lower_src, lower_val;
  logic [KIND_W-1:0]    kind;

  assign cmd = decode_cmd(rx_byte_i);

  // speeds limited by their caps
  assign sd = (drive_speed_q < cfg_i.drive_cap) ? drive_speed_q : cfg_i.drive_cap;
  assign st = (turn_speed_q < cfg_i.turn_cap) ? turn_speed_q : cfg_i.turn_cap;

  // mix selection per command
  always_comb begin
    sel       = '0;
    left_neg  = 1'b0;
    right_neg = 1'b0;
    motion    = 1'b0;
    kind      = KIND_ADJUST;
    unique case (cmd)
      CMD_FWD: begin
        sel = sd; motion = 1'b1; kind = KIND_FWD;
      end
      CMD_BACK: begin
        sel = sd; motion = 1'b1; left_neg = 1'b1; right_neg = 1'b1; kind = KIND_BACK;
      end
      CMD_LEFT: begin
        sel = st; motion = 1'b1; left_neg = 1'b1; kind = KIND_LEFT;
      end
      CMD_RIGHT: begin
        sel = st; motion = 1'b1; right_neg = 1'b1; kind = KIND_RIGHT;
      end
      CMD_STOP: begin
        kind = KIND_STOP;
      end
      CMD_HOME: begin
        kind = KIND_HOME;
      end
      default: begin
        kind = KIND_ADJUST;
      end
    endcase
  end

  // pwm = min(s,100) * 255 / 100 via reciprocal multiply
  assign mag      = (sel > PCT_MAX) ? PCT_MAX : sel;
  assign pwm_prod = {21'd0, mag} * {7'd0, PWM_RECIP};
  assign pwm_new  = pwm_prod[PWM_SHIFT +: PWM_W];

  // right motors 0 and 2, left motors 1 and 3; zero duty counts as forward
  assign neg_vec = {left_neg, right_neg, left_neg, right_neg} &
                   {NUM_MOTOR{mag != '0}};

  // speed raise with cap, lower with floor
  assign raise_src  = (cmd == CMD_TRN_UP) ? {1'b0, turn_speed_q} : {1'b0, drive_speed_q};
  assign raise_cap  = (cmd == CMD_TRN_UP) ? cfg_i.turn_cap : cfg_i.drive_cap;
  assign raise_sum  = raise_src + {1'b0, cfg_i.speed_step};
  assign raise_val  = (raise_sum > {1'b0, raise_cap}) ? raise_cap : raise_sum[SPD_W-1:0];
  assign lower_src  = (cmd == CMD_TRN_DN) ? turn_speed_q : drive_speed_q;
  assign lower_diff = {1'b0, lower_src} - {1'b0, cfg_i.speed_step};
  assign lower_val  = (lower_diff[SPD_W] || (lower_diff[SPD_W-1:0] < cfg_i.speed_floor))
                      ? cfg_i.speed_floor : lower_diff[SPD_W-1:0];

  // next state
  always_comb begin
    drive_speed_d = drive_speed_q;
    turn_speed_d  = turn_speed_q;
    pwm_d         = pwm_q;
    dir_d         = dir_q;
    led_d         = led_q;
    if (cmd == CMD_FWD || cmd == CMD_BACK || cmd == CMD_LEFT ||
        cmd == CMD_RIGHT || cmd == CMD_STOP || cmd == CMD_HOME) begin
      pwm_d = pwm_new;
      dir_d = ~neg_vec ^ cfg_i.invert_mask;
      led_d = motion;
    end
    case (cmd)
      CMD_HOME: begin
        drive_speed_d = cfg_i.speed_default;
        turn_speed_d  = cfg_i.speed_default;
      end
      CMD_DRV_UP: drive_speed_d = raise_val;
      CMD_DRV_DN: drive_speed_d = lower_val;
      CMD_TRN_UP: turn_speed_d  = raise_val;
      CMD_TRN_DN: turn_speed_d  = lower_val;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_speed_q <= SPEED_RST;
      turn_speed_q  <= SPEED_RST;
      pwm_q         <= '0;
      dir_q         <= '0;
      led_q         <= 1'b0;
    end else if (en_i) begin
      drive_speed_q <= drive_speed_d;
      turn_speed_q  <= turn_speed_d;
      pwm_q         <= pwm_d;
      dir_q         <= dir_d;
      led_q         <= led_d;
    end
  end

  // result fields show the state after the command
  assign hit_o             = (cmd != CMD_NONE);
  assign res_o.pwm         = pwm_d;
  assign res_o.dir         = dir_d;
  assign res_o.led         = led_d;
  assign res_o.drive_speed = drive_speed_d;
  assign res_o.turn_speed  = turn_speed_d;
  assign res_o.kind        = kind;

endmodule

// File: rtl/core/skid_steer_command_decoder_top.sv
`timescale 1ns / 1ps
// Skid-steer command decoder, top level.
// Path: a taken command beat is held in the input register, then the decode
// and mix logic write its result into the result register.
// Throughput: one command per cycle while the result side takes its beats; the result register frees the input side.
// Reset: speeds 10, motors stopped, direction bits and LED low, registers at
// their documented defaults. Depends on ssd_pkg, ssd_intf, ssd_cfg, ssd_exec.

module skid_steer_command_decoder_top
  import ssd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  ssd_cmd_if.sink   cmd_i,
  ssd_cfg_if.sink   cfg_i,
  ssd_res_if.source res_o
);

  logic              in_valid_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              out_valid_q;
  res_t              out_q;
  logic              advance;
  logic              hit;
  res_t              res;
  cfg_t              cfg;

  // configuration port always takes a write
  assign cfg_i.ready = 1'b1;

  ssd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.cfg_index),
    .wr_data_i  (cfg_i.cfg_data),
    .cfg_o      (cfg)
  );

  // stage advance when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign cmd_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      in_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      in_byte_q <= cmd_i.rx_byte;
    end
  end

  ssd_exec u_exec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .hit_o     (hit),
    .res_o     (res)
  );

  // result register, unknown bytes leave no beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= hit;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hit) begin
      out_q <= res;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.pwm_right_front = out_q.pwm;
  assign res_o.pwm_left_front  = out_q.pwm;
  assign res_o.pwm_right_back  = out_q.pwm;
  assign res_o.pwm_left_back   = out_q.pwm;
  assign res_o.dir_bits        = out_q.dir;
  assign res_o.led_on          = out_q.led;
  assign res_o.drive_speed_now = out_q.drive_speed;
  assign res_o.turn_speed_now  = out_q.turn_speed;
  assign res_o.command_kind    = out_q.kind;

endmodule

// File: tb/skid_steer_command_decoder_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for skid_steer_command_decoder_top: random command
// bytes and register settings, scoreboard class tracks speeds, motors and LED
// depends on ssd_pkg, ssd_intf and the decoder rtl

module skid_steer_command_decoder_top_tb;
  import ssd_pkg::*;

  localparam int unsigned PWM_FULL      = 255;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 104;
  localparam int unsigned NUM_PHASES    = 8;
  // index with no register behind it, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  // opening sequence: odd bytes, each motion, saturation at cap and floor
  localparam logic [BYTE_W-1:0] OPENING [23] = '{
    8'h00, 8'hFF, "\n", "\r",
    "w", "s", "a", "d", "x",
    "q", "q", "q", "q", "w",
    "z", "z", "z", "z", "z",
    "e", "c", "h", "S"
  };

  typedef struct packed {
    logic [NUM_MOTOR-1:0][PWM_W-1:0] pwm;
    logic [NUM_MOTOR-1:0]            dir;
    logic                            led;
    logic [SPD_W-1:0]                drive_speed;
    logic [SPD_W-1:0]                turn_speed;
    logic [KIND_W-1:0]               kind;
  } motor_status_t;

  // tracks registers, speeds and motor levels, holds the statuses still due
  class motor_state_tracker;
    logic [SPD_W-1:0]                drive_cap, turn_cap, speed_step;
    logic [SPD_W-1:0]                speed_floor, speed_default;
    logic [NUM_MOTOR-1:0]            invert_mask;
    logic [SPD_W-1:0]                drive_speed, turn_speed;
    logic [NUM_MOTOR-1:0][PWM_W-1:0] pwm;
    logic [NUM_MOTOR-1:0]            dir;
    logic                            led;
    motor_status_t                   pending_status[$];
    int unsigned                     mismatches;

    function void power_up();
      drive_cap     = 7'd25;
      turn_cap      = 7'd100;
      speed_step    = 7'd5;
      speed_floor   = 7'd5;
      speed_default = 7'd10;
      invert_mask   = 4'd10;
      drive_speed   = 7'd10;
      turn_speed    = 7'd10;
      pwm           = '0;
      dir           = '0;
      led           = 1'b0;
      mismatches    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_DRIVE_CAP:   drive_cap = data;
        REG_TURN_CAP:    turn_cap = data;
        REG_SPEED_STEP:  speed_step = data;
        REG_SPEED_FLOOR: speed_floor = data;
        REG_SPEED_DFLT:  speed_default = data;
        REG_INVERT_MASK: invert_mask = data[NUM_MOTOR-1:0];
        default: ;
      endcase
    endfunction

    function cmd_e command_of(logic [BYTE_W-1:0] b);
      case (b)
        "w", "W", "f": return CMD_FWD;
        "s", "S", "b": return CMD_BACK;
        "a", "A", "l": return CMD_LEFT;
        "d", "D", "r": return CMD_RIGHT;
        "x", "X", " ": return CMD_STOP;
        "h", "H":      return CMD_HOME;
        "q", "Q":      return CMD_DRV_UP;
        "z", "Z":      return CMD_DRV_DN;
        "e", "E":      return CMD_TRN_UP;
        "c", "C":      return CMD_TRN_DN;
        default:       return CMD_NONE;
      endcase
    endfunction

    // zero duty counts as forward even when reversing
    function void set_motor(int idx, int unsigned speed, bit reverse);
      int unsigned m;
      bit fwd;
      m = (speed > PCT_MAX) ? PCT_MAX : speed;
      fwd = !(reverse && m > 0);
      if (invert_mask[idx]) fwd = !fwd;
      pwm[idx] = PWM_W'((m * PWM_FULL) / PCT_MAX);
      dir[idx] = fwd;
    endfunction

    // right side is motors 0 and 2, left side 1 and 3
    function void set_mix(int unsigned speed, bit left_rev, bit right_rev);
      set_motor(0, speed, right_rev);
      set_motor(1, speed, left_rev);
      set_motor(2, speed, right_rev);
      set_motor(3, speed, left_rev);
    endfunction

    function logic [SPD_W-1:0] raised(logic [SPD_W-1:0] v, logic [SPD_W-1:0] cap);
      int unsigned n;
      n = int'(v) + int'(speed_step);
      return (n > cap) ? cap : SPD_W'(n);
    endfunction

    function logic [SPD_W-1:0] lowered(logic [SPD_W-1:0] v);
      int n;
      n = int'(v) - int'(speed_step);
      return (n < int'(speed_floor)) ? speed_floor : SPD_W'(n);
    endfunction

    function void take_command(logic [BYTE_W-1:0] b);
      cmd_e             c;
      motor_status_t    s;
      logic [SPD_W-1:0] sd, st;
      logic [KIND_W-1:0] kind;
      c = command_of(b);
      if (c == CMD_NONE) return;
      sd = (drive_speed < drive_cap) ? drive_speed : drive_cap;
      st = (turn_speed < turn_cap) ? turn_speed : turn_cap;
      kind = KIND_ADJUST;
      case (c)
        CMD_FWD: begin
          kind = KIND_FWD; led = 1'b1; set_mix(sd, 1'b0, 1'b0);
        end
        CMD_BACK: begin
          kind = KIND_BACK; led = 1'b1; set_mix(sd, 1'b1, 1'b1);
        end
        CMD_LEFT: begin
          kind = KIND_LEFT; led = 1'b1; set_mix(st, 1'b1, 1'b0);
        end
        CMD_RIGHT: begin
          kind = KIND_RIGHT; led = 1'b1; set_mix(st, 1'b0, 1'b1);
        end
        CMD_STOP: begin
          kind = KIND_STOP; led = 1'b0; set_mix(0, 1'b0, 1'b0);
        end
        CMD_HOME: begin
          kind = KIND_HOME; led = 1'b0; set_mix(0, 1'b0, 1'b0);
          drive_speed = speed_default;
          turn_speed  = speed_default;
        end
        CMD_DRV_UP: drive_speed = raised(drive_speed, drive_cap);
        CMD_DRV_DN: drive_speed = lowered(drive_speed);
        CMD_TRN_UP: turn_speed = raised(turn_speed, turn_cap);
        CMD_TRN_DN: turn_speed = lowered(turn_speed);
        default: ;
      endcase
      s.pwm         = pwm;
      s.dir         = dir;
      s.led         = led;
      s.drive_speed = drive_speed;
      s.turn_speed  = turn_speed;
      s.kind        = kind;
      pending_status.push_back(s);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(motor_status_t got);
      motor_status_t want;
      if (pending_status.size() == 0) begin
        $display("%0t: result beat with nothing expected, expected none, actual kind %0d",
                 $time, got.kind);
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      for (int i = 0; i < NUM_MOTOR; i++)
        compare_field($sformatf("pwm motor %0d", i), want.pwm[i], got.pwm[i]);
      compare_field("dir_bits", want.dir, got.dir);
      compare_field("led_on", want.led, got.led);
      compare_field("drive_speed_now", want.drive_speed, got.drive_speed);
      compare_field("turn_speed_now", want.turn_speed, got.turn_speed);
      compare_field("command_kind", want.kind, got.kind);
    endfunction

    function int unsigned open_count();
      return pending_status.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ssd_cmd_if cmd_if ();
  ssd_cfg_if cfg_if ();
  ssd_res_if res_if ();

  motor_state_tracker tracker;
  bit                 hold_off_armed;
  string              letters = "wWfsSbaAldDrxX hHqQzZeEcC";

  skid_steer_command_decoder_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // mostly command letters, some line ends, the rest any byte
  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return letters[$urandom_range(0, letters.len() - 1)];
    if (r < 83) return ($urandom_range(0, 1) != 0) ? "\n" : "\r";
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // register value with weight on the extremes
  function automatic logic [CFG_DATA_W-1:0] pick_setting();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd100;
      2: return 7'd127;
      3: return 7'd1;
      default: return CFG_DATA_W'($urandom_range(0, 100));
    endcase
  endfunction

  // monitor: results are checked before the same edge's command is noted
  always @(posedge clk_i) begin
    motor_status_t got;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        got.pwm[0]      = res_if.pwm_right_front;
        got.pwm[1]      = res_if.pwm_left_front;
        got.pwm[2]      = res_if.pwm_right_back;
        got.pwm[3]      = res_if.pwm_left_back;
        got.dir         = res_if.dir_bits;
        got.led         = res_if.led_on;
        got.drive_speed = res_if.drive_speed_now;
        got.turn_speed  = res_if.turn_speed_now;
        got.kind        = res_if.command_kind;
        tracker.check_status(got);
      end
      if (cmd_if.valid && cmd_if.ready) tracker.take_command(cmd_if.rx_byte);
    end
  end

  // result side: ready follows a stall pattern that is redrawn at random
  initial begin
    int unsigned mode, span, tick;
    res_if.ready <= 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_armed) begin
        hold_off_armed = 1'b0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 64);
      repeat (span) begin
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (tick % 3 == 0);
        endcase
        tick++;
        @(posedge clk_i);
      end
    end
  end

  // one command beat, valid stays high for the caller to continue a burst
  task automatic push_command(input logic [BYTE_W-1:0] b);
    cmd_if.valid   <= 1'b1;
    cmd_if.rx_byte <= b;
    do @(posedge clk_i); while (!cmd_if.ready);
  endtask

  task automatic send_commands(input int unsigned count);
    int unsigned burst_left, gap;
    burst_left = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          cmd_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      push_command(pick_byte());
    end
    cmd_if.valid <= 1'b0;
  endtask

  // one register beat, the caller lowers valid after the last one
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.cfg_index <= idx;
    cfg_if.cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    tracker.set_register(idx, data);
  endtask

  task automatic program_registers(input logic [CFG_DATA_W-1:0] dcap, tcap, step,
                                   input logic [CFG_DATA_W-1:0] floor_v, dflt, mask,
                                   input bit with_unused);
    if (with_unused) write_register(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 127)));
    write_register(REG_DRIVE_CAP, dcap);
    write_register(REG_TURN_CAP, tcap);
    write_register(REG_SPEED_STEP, step);
    write_register(REG_SPEED_FLOOR, floor_v);
    write_register(REG_SPEED_DFLT, dflt);
    write_register(REG_INVERT_MASK, mask);
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every expected status, then for stray work to settle
  task automatic drain();
    while (tracker.open_count() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // main sequence
  initial begin
    tracker = new();
    tracker.power_up();
    hold_off_armed = 1'b0;
    rst_ni           <= 1'b0;
    cmd_if.valid     <= 1'b0;
    cmd_if.rx_byte   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.cfg_index <= '0;
    cfg_if.cfg_data  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (OPENING[i]) push_command(OPENING[i]);
    cmd_if.valid <= 1'b0;
    drain();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        // zero drive cap for reverse at zero speed, clear mask
        0: program_registers(7'd0, 7'd127, 7'd100, 7'd0, 7'd0, 7'd0, 1'b0);
        1: program_registers(7'd100, 7'd0, 7'd1, 7'd100, 7'd100, 7'd15, 1'b0);
        // everything past its documented range
        2: program_registers(7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'h7F, 1'b1);
        default: program_registers(pick_setting(), pick_setting(), pick_setting(),
                                   pick_setting(), pick_setting(),
                                   CFG_DATA_W'($urandom_range(0, 127)),
                                   ($urandom_range(0, 3) == 0));
      endcase
      if (p == 1 || p == 5) hold_off_armed = 1'b1;
      send_commands(PHASE_ITEMS);
      drain();
    end

    if (tracker.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
